FILE: sv/prd_pkg.sv
// Package for the packet receive deframer: shared types, register indexes,
// result codes and the byte-wide CRC-16-CCITT update function.
// Used by every module in the sv folder; depends on nothing else.
package prd_pkg;

  localparam int MAX_PAYLOAD_DEF  = 64;
  localparam int BUFFER_BYTES_DEF = 72;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  SEQ_NONE = 8'hFF;

  localparam logic [7:0]  SYNC_VALUE_RST     = 8'd170;
  localparam logic [7:0]  COMMAND_TYPE_RST   = 8'd16;
  localparam logic [7:0]  ACK_TYPE_RST       = 8'd4;
  localparam logic [7:0]  HANDSHAKE_TYPE_RST = 8'd5;
  localparam logic [15:0] TIMEOUT_MS_RST     = 16'd100;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYNC_VALUE     = 3'd0,
    CFG_COMMAND_TYPE   = 3'd1,
    CFG_ACK_TYPE       = 3'd2,
    CFG_HANDSHAKE_TYPE = 3'd3,
    CFG_TIMEOUT_MS     = 3'd4
  } cfg_idx_t;

  typedef enum logic [2:0] {
    RK_PAYLOAD = 3'd0,
    RK_GOOD    = 3'd1,
    RK_CRC_ERR = 3'd2,
    RK_LEN_ERR = 3'd3,
    RK_TIMEOUT = 3'd4
  } res_kind_t;

  typedef enum logic [6:0] {
    PH_SYNC = 7'b0000001,
    PH_TYPE = 7'b0000010,
    PH_LEN  = 7'b0000100,
    PH_SEQ  = 7'b0001000,
    PH_PAY  = 7'b0010000,
    PH_CRCL = 7'b0100000,
    PH_CRCH = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [7:0]  sync_value;
    logic [7:0]  command_type_min;
    logic [7:0]  ack_type_code;
    logic [7:0]  handshake_type_code;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    res_kind_t   kind;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_type;
    logic [7:0]  frame_length;
    logic [7:0]  frame_seq;
    logic [15:0] frame_crc;
    logic        seq_gap;
    logic        ack_valid;
    logic [7:0]  acked_seq;
    logic        handshake_done;
  } res_t;

  // One byte into the CRC, most significant bit first, eight shift steps.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: sv/prd_parser.sv
// Frame parser: phase register, header and CRC state, and the logic that
// turns one accepted byte or tick into at most one result.
// Depends on prd_pkg.
module prd_parser #(
  parameter int MAX_PAYLOAD  = prd_pkg::MAX_PAYLOAD_DEF,
  parameter int BUFFER_BYTES = prd_pkg::BUFFER_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic           kind,
  input  logic [7:0]     rx_byte,
  input  logic           bypass,
  input  prd_pkg::cfg_t  cfg,
  output logic           res_valid,
  output prd_pkg::res_t  res
);

  localparam int SCW = $clog2(BUFFER_BYTES + 1);
  localparam int CW  = SCW + 1;

  prd_pkg::phase_t phase, phase_next;
  logic [SCW-1:0]  stored_count, stored_count_next;
  logic [7:0]      declared_len, declared_len_next;
  logic [7:0]      header_type, header_type_next;
  logic [7:0]      header_seq, header_seq_next;
  logic [15:0]     crc_accum, crc_accum_next;
  logic [7:0]      crc_low_byte, crc_low_byte_next;
  logic [7:0]      captured_ack_seq, captured_ack_seq_next;
  logic [7:0]      previous_seq, previous_seq_next;
  logic            handshake_flag, handshake_flag_next;
  logic [15:0]     idle_ms, idle_ms_next;

  logic [CW-1:0]   cnt_inc;
  logic            overflow;
  logic            legal;
  logic            check_ovf;
  logic [15:0]     crc_upd;
  logic [15:0]     rx_crc;
  prd_pkg::res_kind_t rk;
  logic [7:0]      pb;
  logic [15:0]     fcrc;
  logic            gap;
  logic            ackv;
  logic [7:0]      ackseq;

  assign cnt_inc  = {1'b0, stored_count} + CW'(1);
  assign overflow = cnt_inc >= CW'(BUFFER_BYTES);
  assign legal    = declared_len <= 8'(MAX_PAYLOAD);
  assign crc_upd  = prd_pkg::crc16_byte(crc_accum, rx_byte);
  assign rx_crc   = {rx_byte, crc_low_byte};

  always_comb begin
    phase_next            = phase;
    stored_count_next     = stored_count;
    declared_len_next     = declared_len;
    header_type_next      = header_type;
    header_seq_next       = header_seq;
    crc_accum_next        = crc_accum;
    crc_low_byte_next     = crc_low_byte;
    captured_ack_seq_next = captured_ack_seq;
    previous_seq_next     = previous_seq;
    handshake_flag_next   = handshake_flag;
    idle_ms_next          = idle_ms;
    res_valid             = 1'b0;
    check_ovf             = 1'b0;
    rk                    = prd_pkg::RK_PAYLOAD;
    pb                    = 8'd0;
    fcrc                  = 16'd0;
    gap                   = 1'b0;
    ackv                  = 1'b0;
    ackseq                = 8'd0;

    if (fire) begin
      if (bypass) begin
        phase_next        = prd_pkg::PH_SYNC;
        stored_count_next = '0;
        declared_len_next = 8'd0;
        crc_accum_next    = prd_pkg::CRC_INIT;
        idle_ms_next      = 16'd0;
      end else if (kind) begin
        if (phase != prd_pkg::PH_SYNC) begin
          if (idle_ms >= cfg.timeout_ms) begin
            phase_next        = prd_pkg::PH_SYNC;
            stored_count_next = '0;
            declared_len_next = 8'd0;
            idle_ms_next      = 16'd0;
            res_valid         = 1'b1;
            rk                = prd_pkg::RK_TIMEOUT;
          end else if (idle_ms != 16'hFFFF) begin
            idle_ms_next = idle_ms + 16'd1;
          end
        end
      end else begin
        idle_ms_next = 16'd0;
        unique case (phase)
          prd_pkg::PH_SYNC: begin
            if (rx_byte == cfg.sync_value) begin
              stored_count_next     = '0;
              declared_len_next     = 8'd0;
              header_type_next      = 8'd0;
              header_seq_next       = 8'd0;
              crc_accum_next        = prd_pkg::CRC_INIT;
              captured_ack_seq_next = 8'd0;
              phase_next            = prd_pkg::PH_TYPE;
            end
          end
          prd_pkg::PH_TYPE: begin
            header_type_next  = rx_byte;
            crc_accum_next    = crc_upd;
            stored_count_next = cnt_inc[SCW-1:0];
            phase_next        = prd_pkg::PH_LEN;
            check_ovf         = 1'b1;
          end
          prd_pkg::PH_LEN: begin
            declared_len_next = rx_byte;
            crc_accum_next    = crc_upd;
            stored_count_next = cnt_inc[SCW-1:0];
            phase_next        = prd_pkg::PH_SEQ;
            check_ovf         = 1'b1;
          end
          prd_pkg::PH_SEQ: begin
            header_seq_next   = rx_byte;
            crc_accum_next    = crc_upd;
            stored_count_next = cnt_inc[SCW-1:0];
            phase_next        = (declared_len != 8'd0) ? prd_pkg::PH_PAY : prd_pkg::PH_CRCL;
            check_ovf         = 1'b1;
          end
          prd_pkg::PH_PAY: begin
            // The second payload byte carries the acknowledged sequence number.
            if (stored_count == SCW'(4)) begin
              captured_ack_seq_next = rx_byte;
            end
            crc_accum_next    = crc_upd;
            stored_count_next = cnt_inc[SCW-1:0];
            if (9'(cnt_inc) >= {1'b0, declared_len} + 9'd3) begin
              phase_next = prd_pkg::PH_CRCL;
            end
            if (overflow) begin
              phase_next        = prd_pkg::PH_SYNC;
              stored_count_next = '0;
              declared_len_next = 8'd0;
              res_valid         = 1'b1;
              rk                = prd_pkg::RK_LEN_ERR;
            end else if (legal) begin
              res_valid = 1'b1;
              rk        = prd_pkg::RK_PAYLOAD;
              pb        = rx_byte;
            end
          end
          prd_pkg::PH_CRCL: begin
            crc_low_byte_next = rx_byte;
            stored_count_next = cnt_inc[SCW-1:0];
            phase_next        = prd_pkg::PH_CRCH;
            check_ovf         = 1'b1;
          end
          prd_pkg::PH_CRCH: begin
            stored_count_next = cnt_inc[SCW-1:0];
            phase_next        = prd_pkg::PH_SYNC;
            res_valid         = 1'b1;
            if (!legal) begin
              rk = prd_pkg::RK_LEN_ERR;
            end else if (rx_crc != crc_accum) begin
              rk   = prd_pkg::RK_CRC_ERR;
              fcrc = rx_crc;
            end else begin
              rk   = prd_pkg::RK_GOOD;
              fcrc = rx_crc;
              gap  = (header_type >= cfg.command_type_min) &&
                     (previous_seq != prd_pkg::SEQ_NONE) &&
                     (header_seq != previous_seq + 8'd1);
              previous_seq_next = header_seq;
              if (header_type == cfg.handshake_type_code) begin
                handshake_flag_next = 1'b1;
              end
              ackv   = (header_type == cfg.ack_type_code) && (declared_len >= 8'd4);
              ackseq = ackv ? captured_ack_seq : 8'd0;
            end
          end
          default: begin
            phase_next        = prd_pkg::PH_SYNC;
            stored_count_next = '0;
            declared_len_next = 8'd0;
          end
        endcase

        // A header byte or the low CRC byte that fills the buffer abandons the frame.
        if (check_ovf && overflow) begin
          phase_next        = prd_pkg::PH_SYNC;
          stored_count_next = '0;
          declared_len_next = 8'd0;
          res_valid         = 1'b1;
          rk                = prd_pkg::RK_LEN_ERR;
        end
      end
    end

    res.kind           = rk;
    res.payload_byte   = pb;
    res.frame_type     = header_type_next;
    res.frame_length   = declared_len_next;
    res.frame_seq      = header_seq_next;
    res.frame_crc      = fcrc;
    res.seq_gap        = gap;
    res.ack_valid      = ackv;
    res.acked_seq      = ackseq;
    res.handshake_done = handshake_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= prd_pkg::PH_SYNC;
      stored_count     <= '0;
      declared_len     <= 8'd0;
      header_type      <= 8'd0;
      header_seq       <= 8'd0;
      crc_accum        <= prd_pkg::CRC_INIT;
      crc_low_byte     <= 8'd0;
      captured_ack_seq <= 8'd0;
      previous_seq     <= prd_pkg::SEQ_NONE;
      handshake_flag   <= 1'b0;
      idle_ms          <= 16'd0;
    end else begin
      phase            <= phase_next;
      stored_count     <= stored_count_next;
      declared_len     <= declared_len_next;
      header_type      <= header_type_next;
      header_seq       <= header_seq_next;
      crc_accum        <= crc_accum_next;
      crc_low_byte     <= crc_low_byte_next;
      captured_ack_seq <= captured_ack_seq_next;
      previous_seq     <= previous_seq_next;
      handshake_flag   <= handshake_flag_next;
      idle_ms          <= idle_ms_next;
    end
  end

  a_bypass_to_sync: assert property (@(posedge clk) disable iff (rst)
    fire && bypass |=> phase == prd_pkg::PH_SYNC)
    else $error("parser not back in sync hunt after bypass");

  a_status_ends_frame: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind != prd_pkg::RK_PAYLOAD |=> phase == prd_pkg::PH_SYNC)
    else $error("status result did not end the frame");

  a_handshake_sticky: assert property (@(posedge clk) disable iff (rst)
    handshake_flag |=> handshake_flag)
    else $error("handshake flag cleared outside reset");

  // The last CRC byte may bring the count up to the buffer size, but only as
  // the frame closes and the parser goes back to the sync hunt.
  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    phase != prd_pkg::PH_SYNC |-> {1'b0, stored_count} < CW'(BUFFER_BYTES))
    else $error("stored byte count reached the buffer size inside a frame");

endmodule

FILE: sv/prd_outbuf.sv
// Two-entry result buffer: an output register and a skid register, so a
// result can be produced while the previous one still waits for its transfer.
// Depends on prd_pkg.
module prd_outbuf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  prd_pkg::res_t push_data,
  output logic          space,
  output logic          head_valid,
  output prd_pkg::res_t head,
  input  logic          pop_ready
);

  logic          skid_valid;
  prd_pkg::res_t skid;
  logic          pop;

  assign space = !skid_valid;
  assign pop   = head_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (head_valid) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      head <= skid;
    end else if (push && (pop || !head_valid)) begin
      head <= push_data;
    end
    if (push && head_valid && !pop) begin
      skid <= push_data;
    end
  end

  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid entry held without an output entry");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> !push)
    else $error("result produced with both entries occupied");

  a_skid_moves_up: assert property (@(posedge clk) disable iff (rst)
    skid_valid && pop_ready |=> head_valid && !skid_valid)
    else $error("skid entry lost on transfer");

endmodule

FILE: sv/packet_receive_deframer_crc16.sv
// Sync-byte packet deframer with CRC-16-CCITT: the top level.
// Holds the configuration registers and joins the parser to the result buffer.
// Depends on prd_pkg, prd_parser and prd_outbuf.
//
// Each input transfer is a received byte or a one millisecond tick; the block
// takes one per clock cycle while in_ready is high, and each leaves at most one
// result. A transfer is decoded and folded into the parser state (including a
// byte-wide CRC update) in the cycle it is accepted, and its result is
// registered in the two-entry result buffer, which keeps the input open while
// one result waits; input ready drops only when both entries are full. Results
// are payload bytes of frames with a legal length and at most one status per
// frame (good, CRC error, length error, timeout). The user must write
// configuration only while the block is idle; the block does not enforce this.
module packet_receive_deframer_crc16 #(
  parameter int MAX_PAYLOAD  = prd_pkg::MAX_PAYLOAD_DEF,
  parameter int BUFFER_BYTES = prd_pkg::BUFFER_BYTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [7:0]                     rx_byte,
  input  logic                           bypass,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     result_kind,
  output logic [7:0]                     payload_byte,
  output logic [7:0]                     frame_type,
  output logic [7:0]                     frame_length,
  output logic [7:0]                     frame_seq,
  output logic [15:0]                    frame_crc,
  output logic                           seq_gap,
  output logic                           ack_valid,
  output logic [7:0]                     acked_seq,
  output logic                           handshake_done,
  input  logic                           cfg_wr_en,
  input  logic [prd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prd_pkg::CFG_DATA_W-1:0] cfg_data
);

  prd_pkg::cfg_t cfg;
  prd_pkg::res_t res;
  prd_pkg::res_t head;
  logic          res_valid;
  logic          fire;

  assign fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_value          <= prd_pkg::SYNC_VALUE_RST;
      cfg.command_type_min    <= prd_pkg::COMMAND_TYPE_RST;
      cfg.ack_type_code       <= prd_pkg::ACK_TYPE_RST;
      cfg.handshake_type_code <= prd_pkg::HANDSHAKE_TYPE_RST;
      cfg.timeout_ms          <= prd_pkg::TIMEOUT_MS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        prd_pkg::CFG_SYNC_VALUE:     cfg.sync_value          <= cfg_data[7:0];
        prd_pkg::CFG_COMMAND_TYPE:   cfg.command_type_min    <= cfg_data[7:0];
        prd_pkg::CFG_ACK_TYPE:       cfg.ack_type_code       <= cfg_data[7:0];
        prd_pkg::CFG_HANDSHAKE_TYPE: cfg.handshake_type_code <= cfg_data[7:0];
        prd_pkg::CFG_TIMEOUT_MS:     cfg.timeout_ms          <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  prd_parser #(
    .MAX_PAYLOAD  (MAX_PAYLOAD),
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .kind      (kind),
    .rx_byte   (rx_byte),
    .bypass    (bypass),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  prd_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .space      (in_ready),
    .head_valid (out_valid),
    .head       (head),
    .pop_ready  (out_ready)
  );

  assign result_kind    = head.kind;
  assign payload_byte   = head.payload_byte;
  assign frame_type     = head.frame_type;
  assign frame_length   = head.frame_length;
  assign frame_seq      = head.frame_seq;
  assign frame_crc      = head.frame_crc;
  assign seq_gap        = head.seq_gap;
  assign ack_valid      = head.ack_valid;
  assign acked_seq      = head.acked_seq;
  assign handshake_done = head.handshake_done;

endmodule

FILE: tb/prd_tb_pkg.sv
// Testbench helpers for the packet receive deframer: the bitwise CRC-16-CCITT
// step shared by the frame builder and the result predictor.
// Depends on prd_pkg for the CRC polynomial.
package prd_tb_pkg;

  // Shift one data bit at a time into the remainder, most significant bit first.
  function automatic logic [15:0] crc_ccitt_next(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ data[i];
      c  = {c[14:0], 1'b0} ^ (fb ? prd_pkg::CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage

FILE: tb/prd_frame_checker.sv
// Frame checker for the packet receive deframer: watches both channels and the
// register port, predicts every result and compares it field by field.
// Depends on prd_pkg and prd_tb_pkg.
module prd_frame_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           kind,
  input  logic [7:0]                     rx_byte,
  input  logic                           bypass,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [2:0]                     result_kind,
  input  logic [7:0]                     payload_byte,
  input  logic [7:0]                     frame_type,
  input  logic [7:0]                     frame_length,
  input  logic [7:0]                     frame_seq,
  input  logic [15:0]                    frame_crc,
  input  logic                           seq_gap,
  input  logic                           ack_valid,
  input  logic [7:0]                     acked_seq,
  input  logic                           handshake_done,
  input  logic                           cfg_wr_en,
  input  logic [prd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             checked,
  output int                             good_frames,
  output int                             error_statuses
);
  import prd_pkg::*;
  import prd_tb_pkg::*;

  cfg_t        settings;
  phase_t      phase;
  int unsigned stored;
  logic [7:0]  decl_len, hdr_type, hdr_seq, crc_lo, ack_seq_cap, last_seq;
  logic [15:0] crc_run, idle_ticks;
  logic        hs_seen;
  res_t        frame_results_due [$];

  function automatic void clear_parser();
    phase    = PH_SYNC;
    stored   = 0;
    decl_len = 8'd0;
  endfunction

  function automatic void reset_model();
    settings.sync_value          = SYNC_VALUE_RST;
    settings.command_type_min    = COMMAND_TYPE_RST;
    settings.ack_type_code       = ACK_TYPE_RST;
    settings.handshake_type_code = HANDSHAKE_TYPE_RST;
    settings.timeout_ms          = TIMEOUT_MS_RST;
    clear_parser();
    hdr_type    = 8'd0;
    hdr_seq     = 8'd0;
    crc_run     = CRC_INIT;
    crc_lo      = 8'd0;
    ack_seq_cap = 8'd0;
    last_seq    = SEQ_NONE;
    hs_seen     = 1'b0;
    idle_ticks  = 16'd0;
  endfunction

  // Header fields always reflect the parser as it stands after the transfer.
  function automatic res_t status_of(input res_kind_t k, input logic [7:0] pb,
                                     input logic [15:0] crc, input logic gap,
                                     input logic ackv, input logic [7:0] aseq);
    res_t r;
    r.kind           = k;
    r.payload_byte   = pb;
    r.frame_type     = hdr_type;
    r.frame_length   = decl_len;
    r.frame_seq      = hdr_seq;
    r.frame_crc      = crc;
    r.seq_gap        = gap;
    r.ack_valid      = ackv;
    r.acked_seq      = aseq;
    r.handshake_done = hs_seen;
    return r;
  endfunction

  function automatic bit parse_transfer(input logic k, input logic [7:0] b, input logic byp,
                                        output res_t r);
    bit          legal;
    logic [15:0] rx_crc;
    logic [7:0]  next_seq;
    logic        gap, ackv;
    r = '0;
    if (byp) begin
      clear_parser();
      crc_run    = CRC_INIT;
      idle_ticks = 16'd0;
      return 0;
    end
    if (k) begin
      if (phase == PH_SYNC) return 0;
      if (idle_ticks >= settings.timeout_ms) begin
        clear_parser();
        idle_ticks = 16'd0;
        r = status_of(RK_TIMEOUT, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0);
        return 1;
      end
      if (idle_ticks != 16'hFFFF) idle_ticks++;
      return 0;
    end
    idle_ticks = 16'd0;
    legal = (decl_len <= MAX_PAYLOAD_DEF);
    case (phase)
      PH_SYNC: begin
        if (b == settings.sync_value) begin
          stored      = 0;
          decl_len    = 8'd0;
          hdr_type    = 8'd0;
          hdr_seq     = 8'd0;
          crc_run     = CRC_INIT;
          ack_seq_cap = 8'd0;
          phase       = PH_TYPE;
        end
        return 0;
      end
      PH_TYPE: begin
        hdr_type = b;
        crc_run  = crc_ccitt_next(crc_run, b);
        stored++;
        phase = PH_LEN;
      end
      PH_LEN: begin
        decl_len = b;
        crc_run  = crc_ccitt_next(crc_run, b);
        stored++;
        phase = PH_SEQ;
      end
      PH_SEQ: begin
        hdr_seq = b;
        crc_run = crc_ccitt_next(crc_run, b);
        stored++;
        phase = (decl_len != 8'd0) ? PH_PAY : PH_CRCL;
      end
      PH_PAY: begin
        if (stored - 3 == 1) ack_seq_cap = b;
        crc_run = crc_ccitt_next(crc_run, b);
        stored++;
        if (stored >= 3 + decl_len) phase = PH_CRCL;
        // A full buffer wins over passing the byte out.
        if (stored >= BUFFER_BYTES_DEF) begin
          clear_parser();
          r = status_of(RK_LEN_ERR, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0);
          return 1;
        end
        if (legal) begin
          r = status_of(RK_PAYLOAD, b, 16'd0, 1'b0, 1'b0, 8'd0);
          return 1;
        end
        return 0;
      end
      PH_CRCL: begin
        crc_lo = b;
        stored++;
        phase = PH_CRCH;
      end
      PH_CRCH: begin
        stored++;
        phase = PH_SYNC;
        if (!legal) begin
          r = status_of(RK_LEN_ERR, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0);
          return 1;
        end
        rx_crc = {b, crc_lo};
        if (rx_crc != crc_run) begin
          r = status_of(RK_CRC_ERR, 8'd0, rx_crc, 1'b0, 1'b0, 8'd0);
          return 1;
        end
        next_seq = last_seq + 8'd1;
        gap = (hdr_type >= settings.command_type_min) && (last_seq != SEQ_NONE) &&
              (hdr_seq != next_seq);
        last_seq = hdr_seq;
        if (hdr_type == settings.handshake_type_code) hs_seen = 1'b1;
        ackv = (hdr_type == settings.ack_type_code) && (decl_len >= 8'd4);
        r = status_of(RK_GOOD, 8'd0, rx_crc, gap, ackv, ackv ? ack_seq_cap : 8'd0);
        return 1;
      end
      default: begin
        clear_parser();
        return 0;
      end
    endcase
    if (stored >= BUFFER_BYTES_DEF) begin
      clear_parser();
      r = status_of(RK_LEN_ERR, 8'd0, 16'd0, 1'b0, 1'b0, 8'd0);
      return 1;
    end
    return 0;
  endfunction

  function automatic int field_differs(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    res_t want, got;
    int   bad;
    if (rst) begin
      reset_model();
      frame_results_due.delete();
      fail_count     = 0;
      checked        = 0;
      good_frames    = 0;
      error_statuses = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SYNC_VALUE:     settings.sync_value          = cfg_data[7:0];
          CFG_COMMAND_TYPE:   settings.command_type_min    = cfg_data[7:0];
          CFG_ACK_TYPE:       settings.ack_type_code       = cfg_data[7:0];
          CFG_HANDSHAKE_TYPE: settings.handshake_type_code = cfg_data[7:0];
          CFG_TIMEOUT_MS:     settings.timeout_ms          = cfg_data;
          default: ;
        endcase
      end
      // A result cannot leave in the cycle its transfer came in, so checking
      // before predicting keeps the queue in order.
      if (out_valid && out_ready) begin
        got.kind           = res_kind_t'(result_kind);
        got.payload_byte   = payload_byte;
        got.frame_type     = frame_type;
        got.frame_length   = frame_length;
        got.frame_seq      = frame_seq;
        got.frame_crc      = frame_crc;
        got.seq_gap        = seq_gap;
        got.ack_valid      = ack_valid;
        got.acked_seq      = acked_seq;
        got.handshake_done = handshake_done;
        if (frame_results_due.size() == 0) begin
          $display("%0t: result of kind %0d with no transfer awaiting it", $time, result_kind);
          fail_count++;
        end else begin
          want = frame_results_due.pop_front();
          bad  = 0;
          bad += field_differs("result_kind", 16'(want.kind), 16'(got.kind));
          bad += field_differs("payload_byte", 16'(want.payload_byte),
                               16'(got.payload_byte));
          bad += field_differs("frame_type", 16'(want.frame_type), 16'(got.frame_type));
          bad += field_differs("frame_length", 16'(want.frame_length),
                               16'(got.frame_length));
          bad += field_differs("frame_seq", 16'(want.frame_seq), 16'(got.frame_seq));
          bad += field_differs("frame_crc", want.frame_crc, got.frame_crc);
          bad += field_differs("seq_gap", 16'(want.seq_gap), 16'(got.seq_gap));
          bad += field_differs("ack_valid", 16'(want.ack_valid), 16'(got.ack_valid));
          bad += field_differs("acked_seq", 16'(want.acked_seq), 16'(got.acked_seq));
          bad += field_differs("handshake_done", 16'(want.handshake_done),
                               16'(got.handshake_done));
          if (bad != 0) fail_count++;
          checked++;
          if (want.kind == RK_GOOD) good_frames++;
          else if (want.kind != RK_PAYLOAD) error_statuses++;
        end
      end
      if (in_valid && in_ready) begin
        if (parse_transfer(kind, rx_byte, bypass, want)) frame_results_due.push_back(want);
      end
    end
    pending = frame_results_due.size();
  end

endmodule

FILE: tb/packet_receive_deframer_crc16_test.sv
// Top of the deframer testbench: clock, reset, frame stimulus, receiver
// back-pressure and the verdict. Depends on prd_pkg, prd_tb_pkg, the block
// and prd_frame_checker, which does all prediction and comparison.
module packet_receive_deframer_crc16_test;
  import prd_pkg::*;
  import prd_tb_pkg::*;

  logic                  clk;
  logic                  rst;
  logic                  in_valid, in_ready;
  logic                  kind;
  logic [7:0]            rx_byte;
  logic                  bypass;
  logic                  out_valid, out_ready;
  logic [2:0]            result_kind;
  logic [7:0]            payload_byte, frame_type, frame_length, frame_seq, acked_seq;
  logic [15:0]           frame_crc;
  logic                  seq_gap, ack_valid, handshake_done;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count, pending, checked, good_frames, error_statuses;

  // Stimulus-side view of the current settings, used to build frames.
  logic [7:0]  cur_sync, cur_cmd, cur_ack, cur_hs;
  logic [15:0] cur_timeout;
  logic [7:0]  seq_next;
  int          items_sent;
  int          tick_pct;
  bit          send_calm, recv_calm, squeeze_req;
  int          holdoffs;

  packet_receive_deframer_crc16 u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .rx_byte(rx_byte), .bypass(bypass),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .payload_byte(payload_byte),
    .frame_type(frame_type), .frame_length(frame_length), .frame_seq(frame_seq),
    .frame_crc(frame_crc), .seq_gap(seq_gap), .ack_valid(ack_valid),
    .acked_seq(acked_seq), .handshake_done(handshake_done),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  prd_frame_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .rx_byte(rx_byte), .bypass(bypass),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_kind(result_kind), .payload_byte(payload_byte),
    .frame_type(frame_type), .frame_length(frame_length), .frame_seq(frame_seq),
    .frame_crc(frame_crc), .seq_gap(seq_gap), .ack_valid(ack_valid),
    .acked_seq(acked_seq), .handshake_done(handshake_done),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .checked(checked),
    .good_frames(good_frames), .error_statuses(error_statuses)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("%0t: run did not finish in time", $time);
    $display("** packet_receive_deframer_crc16: FAILED **");
    $finish;
  end

  // Receiver: random back-pressure, occasional long stalls, and one hold-off
  // on request that is long enough to fill the result buffer.
  initial begin
    int r;
    int stall_left;
    bit squeeze_done;
    stall_left   = 0;
    squeeze_done = 1'b0;
    out_ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze_req && !squeeze_done) begin
        out_ready <= 1'b0;
        repeat (40) @(negedge clk);
        squeeze_done = 1'b1;
        holdoffs++;
      end else if (recv_calm) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) stall_left = $urandom_range(8, 30);
        out_ready <= (r >= 25);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (send_calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // One transfer; called at a falling edge and returns at a falling edge.
  task automatic send(input logic k, input logic [7:0] b, input logic byp);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    rx_byte  <= b;
    bypass   <= byp;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    items_sent++;
  endtask

  // Drop input valid, wait for every expected result, then let the parser idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic apply_config(input logic [7:0] sv, input logic [7:0] cm, input logic [7:0] ak,
                              input logic [7:0] hs, input logic [15:0] to);
    logic [15:0] vals [5];
    cfg_idx_t    order [5];
    logic [15:0] data;
    vals  = '{{8'd0, sv}, {8'd0, cm}, {8'd0, ak}, {8'd0, hs}, to};
    order = '{CFG_SYNC_VALUE, CFG_COMMAND_TYPE, CFG_ACK_TYPE, CFG_HANDSHAKE_TYPE,
              CFG_TIMEOUT_MS};
    cur_sync    = sv;
    cur_cmd     = cm;
    cur_ack     = ak;
    cur_hs      = hs;
    cur_timeout = to;
    for (int i = 0; i < 5; i++) begin
      data = vals[i];
      // Byte-wide registers must ignore the upper half of the write data.
      if (order[i] != CFG_TIMEOUT_MS) data[15:8] = rand_byte();
      cfg_wr_en <= 1'b1;
      cfg_index <= order[i];
      cfg_data  <= data;
      @(negedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  // A frame stops early when cut is a byte position; the parser is then left
  // to time out or is cleared by a bypass transfer.
  task automatic send_frame(input logic [7:0] ty, input logic [7:0] ln, input logic [7:0] sq,
                            input bit bad_crc, input int cut);
    logic [7:0]  body [$];
    logic [15:0] crc;
    int          n;
    n = (ln > 70) ? 70 : ln;
    body.push_back(ty);
    body.push_back(ln);
    body.push_back(sq);
    repeat (n) body.push_back(rand_byte());
    crc = CRC_INIT;
    foreach (body[i]) crc = crc_ccitt_next(crc, body[i]);
    if (bad_crc) crc ^= 16'h0001 << $urandom_range(0, 15);
    body.push_back(crc[7:0]);
    body.push_back(crc[15:8]);
    send(1'b0, cur_sync, 1'b0);
    for (int i = 0; i < body.size(); i++) begin
      if (i == cut) break;
      if ($urandom_range(0, 99) < tick_pct) send(1'b1, rand_byte(), 1'b0);
      send(1'b0, body[i], 1'b0);
    end
    if (cut >= 0) begin
      if (cur_timeout <= 16'd8 && $urandom_range(0, 1) == 1) begin
        repeat (int'(cur_timeout) + 1) send(1'b1, rand_byte(), 1'b0);
      end else begin
        send(1'($urandom_range(0, 1)), rand_byte(), 1'b1);
      end
    end
    seq_next = sq + 8'd1;
  endtask

  task automatic random_frame();
    logic [7:0] ty, sq;
    int         ln, r, cut;
    r = $urandom_range(0, 99);
    if (r < 25) ty = cur_ack;
    else if (r < 40) ty = cur_hs;
    else if (r < 75) ty = 8'($urandom_range(int'(cur_cmd), 255));
    else ty = rand_byte();
    r = $urandom_range(0, 99);
    if (r < 62) ln = $urandom_range(0, 6);
    else if (r < 88) ln = $urandom_range(4, 16);
    else if (r < 94) ln = $urandom_range(17, 63);
    else if (r < 96) ln = 64;
    else if (r < 98) ln = $urandom_range(65, 68);
    else if (r < 99) ln = $urandom_range(69, 72);
    else ln = 255;
    r = $urandom_range(0, 99);
    if (r < 60) sq = seq_next;
    else if (r < 70) sq = SEQ_NONE;
    else sq = rand_byte();
    cut = ($urandom_range(0, 99) < 8) ? int'($urandom_range(0, ((ln > 70) ? 70 : ln) + 4))
                                      : -1;
    send_frame(ty, 8'(ln), sq, $urandom_range(0, 99) < 12, cut);
  endtask

  task automatic random_unit();
    int         r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 75) begin
      random_frame();
    end else if (r < 85) begin
      // Line noise between frames; keep clear of the sync value.
      repeat ($urandom_range(1, 4)) begin
        b = rand_byte();
        if (b == cur_sync) b = b ^ 8'h01;
        send(1'b0, b, 1'b0);
      end
    end else if (r < 93) begin
      repeat ($urandom_range(1, 3)) send(1'b1, rand_byte(), 1'b0);
    end else begin
      send(1'($urandom_range(0, 1)), rand_byte(), 1'b1);
    end
  endtask

  initial begin
    int          special_len [6];
    int          phase_end;
    logic [15:0] to;
    special_len = '{64, 65, 67, 68, 69, 255};
    rst         = 1'b1;
    in_valid    = 1'b0;
    kind        = 1'b0;
    rx_byte     = 8'd0;
    bypass      = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    cur_sync    = SYNC_VALUE_RST;
    cur_cmd     = COMMAND_TYPE_RST;
    cur_ack     = ACK_TYPE_RST;
    cur_hs      = HANDSHAKE_TYPE_RST;
    cur_timeout = TIMEOUT_MS_RST;
    seq_next    = 8'd0;
    items_sent  = 0;
    tick_pct    = 0;
    send_calm   = 1'b0;
    recv_calm   = 1'b0;
    squeeze_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed frames under the reset settings: a first command frame with no
    // sequence history, an ACK with sequence 255, then a handshake that must
    // go unchecked, and a bypass that drops a partial frame.
    send_frame(8'h20, 8'd0, 8'h00, 1'b0, -1);
    send_frame(cur_ack, 8'd4, SEQ_NONE, 1'b0, -1);
    send_frame(cur_hs, 8'd0, 8'h10, 1'b0, -1);
    send(1'b0, cur_sync, 1'b0);
    send(1'b0, 8'h33, 1'b0);
    send(1'b1, 8'hFF, 1'b1);

    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: apply_config(SYNC_VALUE_RST, COMMAND_TYPE_RST, ACK_TYPE_RST, HANDSHAKE_TYPE_RST, 16'd2);
        1: apply_config(8'h00, 8'h00, 8'h00, 8'hFF, 16'd0);
        2: apply_config(8'hFF, 8'hFF, 8'hFF, 8'h00, 16'd1);
        default: begin
          to = 16'($urandom_range(1, 6));
          apply_config(rand_byte(), rand_byte(), rand_byte(), rand_byte(), to);
        end
      endcase
      send_calm = (p % 3 == 1);
      recv_calm = (p % 3 == 2);
      tick_pct  = (p == 1) ? 2 : 5;
      // The first phase opens with a full-length frame against a stalled
      // receiver, so the result buffer fills and input ready must drop.
      if (p == 0) squeeze_req = 1'b1;
      send_frame(cur_cmd, 8'(special_len[p]), seq_next, 1'b0, -1);
      phase_end = items_sent + 20;
      while (items_sent < phase_end) random_unit();
    end

    // Widest timeout: a partial frame must survive a run of ticks and is then
    // dropped by a bypass transfer.
    settle();
    apply_config(rand_byte(), rand_byte(), rand_byte(), rand_byte(), 16'hFFFF);
    send_calm = 1'b1;
    recv_calm = 1'b1;
    tick_pct  = 0;
    send(1'b0, cur_sync, 1'b0);
    send(1'b0, 8'h42, 1'b0);
    repeat (20) send(1'b1, rand_byte(), 1'b0);
    send(1'b0, 8'h00, 1'b1);
    send_frame(cur_cmd, 8'd2, seq_next, 1'b0, -1);

    in_valid <= 1'b0;
    phase_end = 0;
    while (pending != 0 && phase_end < 5000) begin
      @(negedge clk);
      phase_end++;
    end
    repeat (8) @(negedge clk);
    $display("Covered %0d input transfers over seven register settings, incl. the widest timeout.",
             items_sent);
    $display("Compared %0d results: %0d good frames, %0d error statuses; %0d long hold-off(s).",
             checked, good_frames, error_statuses, holdoffs);
    if (fail_count == 0 && pending == 0) begin
      $display("** packet_receive_deframer_crc16: PASSED **");
    end else begin
      if (pending != 0) $display("%0t: %0d expected result(s) never arrived", $time, pending);
      $display("** packet_receive_deframer_crc16: FAILED **");
    end
    $finish;
  end

endmodule
